// File: rtl/core/sdmc_pkg.sv
// shared constants and codes for the static direct-mapped cache
package sdmc_pkg;

  // default sizes handed to the top level
  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned ID_BITS_DEF    = 20;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned OP_W           = 2;
  localparam int unsigned SLOT_COUNT_W   = 11;
  localparam int unsigned UNIT_LIMIT_W   = 21;
  localparam int unsigned CFG_DATA_W     = 21;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned SLOT_INDEX_W   = 10;
  localparam int unsigned TOTAL_W        = 32;

  // register reset values
  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [UNIT_LIMIT_W-1:0] UNIT_LIMIT_RST = 21'd1048576;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LIMIT = 1'd1;

  // operation codes
  localparam logic [OP_W-1:0] OP_PRELOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

endpackage

// File: rtl/core/static_direct_mapped_cache.sv
// static direct-mapped cache of unit ids with lookup and hit counters
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o    operation, unit_id, eligible, contained_count
//   out      output     out_valid_o / out_stall_i  hit, slot_index, access_count, hit_count
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// preload and lookup: one beat accept, one remainder bit per cycle in the shared restoring
// subtractor, then a slot read and a slot check that updates the slot on a preload. clear
// and unknown operations go from the beat accept straight to the slot check.
// after reset a clearing pass over all SLOTS slots (1024 by default) zeroes the slot memory;
// in_stall_o stays high through it, configuration writes are taken as ever.
// one item is in flight at a time; a finished result waits in the output register while
// the next item is taken, and the slot update waits only if that register is still full.
module static_direct_mapped_cache #(
  parameter int unsigned SLOTS      = sdmc_pkg::SLOTS_DEF,
  parameter int unsigned ID_BITS    = sdmc_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = sdmc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sdmc_pkg::OP_W-1:0]         operation_i,
  input  logic [ID_BITS-1:0]                unit_id_i,
  input  logic                              eligible_i,
  input  logic [COUNT_BITS-1:0]             contained_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [sdmc_pkg::SLOT_INDEX_W-1:0] slot_index_o,
  output logic [sdmc_pkg::TOTAL_W-1:0]      access_count_o,
  output logic [sdmc_pkg::TOTAL_W-1:0]      hit_count_o,
  input  logic                              cfg_we_i,
  input  logic [sdmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sdmc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EFF_W  = $clog2(SLOTS + 1);
  localparam int unsigned BIT_W  = $clog2(ID_BITS);
  localparam int unsigned WORD_W = ID_BITS + COUNT_BITS;
  localparam int unsigned TW     = sdmc_pkg::TOTAL_W;
  localparam int unsigned LW     = sdmc_pkg::UNIT_LIMIT_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;

  logic [2:0]                            state_q, state_d;
  logic [sdmc_pkg::SLOT_COUNT_W-1:0]     slot_count_q, slot_count_d;
  logic [LW-1:0]                         unit_limit_q, unit_limit_d;
  logic [sdmc_pkg::OP_W-1:0]             op_q, op_d;
  logic [ID_BITS-1:0]                    id_q, id_d;
  logic [ID_BITS-1:0]                    shift_q, shift_d;
  logic                                  elig_q, elig_d;
  logic [COUNT_BITS-1:0]                 cnt_q, cnt_d;
  logic [EFF_W-1:0]                      eff_q, eff_d;
  logic [EFF_W-1:0]                      rem_q, rem_d;
  logic [BIT_W-1:0]                      bit_q, bit_d;
  logic [SLOT_W-1:0]                     clr_idx_q, clr_idx_d;
  logic [TW-1:0]                         lookup_total_q, lookup_total_d;
  logic [TW-1:0]                         hit_total_q, hit_total_d;
  logic                                  out_valid_q, out_valid_d;
  logic                                  hit_q, hit_d;
  logic [sdmc_pkg::SLOT_INDEX_W-1:0]     slot_index_q, slot_index_d;
  logic [TW-1:0]                         access_count_q, access_count_d;
  logic [TW-1:0]                         hit_count_q, hit_count_d;

  // slot memory: tag over best count; a zero best count marks an empty slot
  logic [WORD_W-1:0] mem [SLOTS];
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_wa, mem_ra;
  logic [WORD_W-1:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  // effective slot count: min with unit limit, then saturate into 1..SLOTS
  logic [LW-1:0] eff_lim, eff_sat;
  always_comb begin
    eff_lim = (unit_limit_q < LW'(slot_count_q)) ? unit_limit_q : LW'(slot_count_q);
    eff_sat = eff_lim;
    if (eff_lim == '0) begin
      eff_sat = LW'(1);
    end else if (eff_lim > LW'(SLOTS)) begin
      eff_sat = LW'(SLOTS);
    end
  end

  // one restoring remainder step
  logic [EFF_W:0]   trial;
  logic [EFF_W:0]   trial_sub;
  logic [EFF_W-1:0] rem_step;
  assign trial     = {rem_q, shift_q[ID_BITS-1]};
  assign trial_sub = trial - {1'b0, eff_q};
  assign rem_step  = (trial >= {1'b0, eff_q}) ? trial_sub[EFF_W-1:0] : trial[EFF_W-1:0];

  logic [SLOT_W-1:0]     slot;
  logic [TW-1:0]         slot_ext;
  logic [ID_BITS-1:0]    rd_tag;
  logic [COUNT_BITS-1:0] rd_best;
  logic                  is_preload, is_lookup, can_out, lookup_hit, take_cand;
  assign slot       = rem_q[SLOT_W-1:0];
  assign slot_ext   = TW'(slot);
  assign rd_tag     = mem_rd_q[WORD_W-1:COUNT_BITS];
  assign rd_best    = mem_rd_q[COUNT_BITS-1:0];
  assign is_preload = (op_q == sdmc_pkg::OP_PRELOAD);
  assign is_lookup  = (op_q == sdmc_pkg::OP_LOOKUP);
  assign can_out    = !out_valid_q || !out_stall_i;
  assign lookup_hit = is_lookup && (rd_best != '0) && (rd_tag == id_q);
  assign take_cand  = is_preload && (64'(id_q) < 64'(unit_limit_q)) && elig_q &&
                      (cnt_q > rd_best);

  always_comb begin
    state_d        = state_q;
    slot_count_d   = slot_count_q;
    unit_limit_d   = unit_limit_q;
    op_d           = op_q;
    id_d           = id_q;
    shift_d        = shift_q;
    elig_d         = elig_q;
    cnt_d          = cnt_q;
    eff_d          = eff_q;
    rem_d          = rem_q;
    bit_d          = bit_q;
    clr_idx_d      = clr_idx_q;
    lookup_total_d = lookup_total_q;
    hit_total_d    = hit_total_q;
    out_valid_d    = out_valid_q && out_stall_i;
    hit_d          = hit_q;
    slot_index_d   = slot_index_q;
    access_count_d = access_count_q;
    hit_count_d    = hit_count_q;
    mem_we         = 1'b0;
    mem_wa         = slot;
    mem_wd         = {id_q, cnt_q};
    mem_re         = 1'b0;
    mem_ra         = slot;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        sdmc_pkg::CFG_SLOT_COUNT: slot_count_d = cfg_data_i[sdmc_pkg::SLOT_COUNT_W-1:0];
        sdmc_pkg::CFG_UNIT_LIMIT: unit_limit_d = cfg_data_i[LW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_idx_q;
        mem_wd    = '0;
        clr_idx_d = clr_idx_q + SLOT_W'(1);
        if (clr_idx_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          id_d    = unit_id_i;
          shift_d = unit_id_i;
          elig_d  = eligible_i;
          cnt_d   = contained_count_i;
          eff_d   = eff_sat[EFF_W-1:0];
          rem_d   = '0;
          bit_d   = BIT_W'(ID_BITS - 1);
          if (operation_i == sdmc_pkg::OP_PRELOAD || operation_i == sdmc_pkg::OP_LOOKUP) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_DIV: begin
        rem_d   = rem_step;
        shift_d = shift_q << 1;
        bit_d   = bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (can_out) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          hit_d       = lookup_hit;
          mem_we      = take_cand;
          if (is_lookup) begin
            lookup_total_d = lookup_total_q + TW'(1);
            if (lookup_hit) begin
              hit_total_d = hit_total_q + TW'(1);
            end
          end else if (op_q == sdmc_pkg::OP_CLEAR) begin
            lookup_total_d = '0;
            hit_total_d    = '0;
          end
          slot_index_d   = (is_preload || is_lookup) ?
                           slot_ext[sdmc_pkg::SLOT_INDEX_W-1:0] : '0;
          access_count_d = lookup_total_d;
          hit_count_d    = hit_total_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      slot_count_q   <= sdmc_pkg::SLOT_COUNT_RST;
      unit_limit_q   <= sdmc_pkg::UNIT_LIMIT_RST;
      op_q           <= sdmc_pkg::OP_PRELOAD;
      id_q           <= '0;
      shift_q        <= '0;
      elig_q         <= 1'b0;
      cnt_q          <= '0;
      eff_q          <= '0;
      rem_q          <= '0;
      bit_q          <= '0;
      clr_idx_q      <= '0;
      lookup_total_q <= '0;
      hit_total_q    <= '0;
      out_valid_q    <= 1'b0;
      hit_q          <= 1'b0;
      slot_index_q   <= '0;
      access_count_q <= '0;
      hit_count_q    <= '0;
    end else begin
      state_q        <= state_d;
      slot_count_q   <= slot_count_d;
      unit_limit_q   <= unit_limit_d;
      op_q           <= op_d;
      id_q           <= id_d;
      shift_q        <= shift_d;
      elig_q         <= elig_d;
      cnt_q          <= cnt_d;
      eff_q          <= eff_d;
      rem_q          <= rem_d;
      bit_q          <= bit_d;
      clr_idx_q      <= clr_idx_d;
      lookup_total_q <= lookup_total_d;
      hit_total_q    <= hit_total_d;
      out_valid_q    <= out_valid_d;
      hit_q          <= hit_d;
      slot_index_q   <= slot_index_d;
      access_count_q <= access_count_d;
      hit_count_q    <= hit_count_d;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign slot_index_o   = slot_index_q;
  assign access_count_o = access_count_q;
  assign hit_count_o    = hit_count_q;

endmodule

// File: rtl/core/sdmc_chk.sv
// port-level checks for the static direct-mapped cache, bound to the top level
module sdmc_chk #(
  parameter int unsigned ID_BITS    = sdmc_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = sdmc_pkg::COUNT_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [sdmc_pkg::OP_W-1:0]         operation_i,
  input logic [ID_BITS-1:0]                unit_id_i,
  input logic                              eligible_i,
  input logic [COUNT_BITS-1:0]             contained_count_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              hit_o,
  input logic [sdmc_pkg::SLOT_INDEX_W-1:0] slot_index_o,
  input logic [sdmc_pkg::TOTAL_W-1:0]      access_count_o,
  input logic [sdmc_pkg::TOTAL_W-1:0]      hit_count_o
);

  // a stalled input beat holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operation_i) &&
      $stable(unit_id_i) && $stable(eligible_i) && $stable(contained_count_i))
    else $error("input beat changed while stalled");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) &&
      $stable(slot_index_o) && $stable(access_count_o) && $stable(hit_count_o))
    else $error("result beat changed while stalled");

  // a result beat leaves only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> !$past(out_stall_i))
    else $error("result beat dropped without handshake");

  // one item at a time: after an accepted beat the input stalls
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // the slot clearing pass blocks the input right after reset
  a_clear_pass: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open during slot clearing pass");

endmodule

bind static_direct_mapped_cache sdmc_chk #(
  .ID_BITS   (ID_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_sdmc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .operation_i      (operation_i),
  .unit_id_i        (unit_id_i),
  .eligible_i       (eligible_i),
  .contained_count_i(contained_count_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .hit_o            (hit_o),
  .slot_index_o     (slot_index_o),
  .access_count_o   (access_count_o),
  .hit_count_o      (hit_count_o)
);

// File: tb/tb.sv
// self-checking testbench for the static direct-mapped cache
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ID_W          = sdmc_pkg::ID_BITS_DEF;
  localparam int unsigned CNT_W         = sdmc_pkg::COUNT_BITS_DEF;
  localparam int unsigned SLOT_N        = sdmc_pkg::SLOTS_DEF;
  localparam logic [ID_W-1:0] ID_MAX    = '1;
  localparam int unsigned POOL_N        = 16;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [sdmc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                              hit;
    logic [sdmc_pkg::SLOT_INDEX_W-1:0] slot;
    logic [sdmc_pkg::TOTAL_W-1:0]      accesses;
    logic [sdmc_pkg::TOTAL_W-1:0]      hits;
  } cache_result_t;

  logic                              clk_i             = 1'b0;
  logic                              rst_ni            = 1'b0;
  logic                              in_valid_i        = 1'b0;
  logic                              in_stall_o;
  logic [sdmc_pkg::OP_W-1:0]         operation_i       = sdmc_pkg::OP_PRELOAD;
  logic [ID_W-1:0]                   unit_id_i         = '0;
  logic                              eligible_i        = 1'b0;
  logic [CNT_W-1:0]                  contained_count_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i       = 1'b0;
  logic                              hit_o;
  logic [sdmc_pkg::SLOT_INDEX_W-1:0] slot_index_o;
  logic [sdmc_pkg::TOTAL_W-1:0]      access_count_o;
  logic [sdmc_pkg::TOTAL_W-1:0]      hit_count_o;
  logic                              cfg_we_i          = 1'b0;
  logic [sdmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i         = sdmc_pkg::CFG_SLOT_COUNT;
  logic [sdmc_pkg::CFG_DATA_W-1:0]   cfg_data_i        = '0;

  static_direct_mapped_cache u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .unit_id_i         (unit_id_i),
    .eligible_i        (eligible_i),
    .contained_count_i (contained_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .slot_index_o      (slot_index_o),
    .access_count_o    (access_count_o),
    .hit_count_o       (hit_count_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the cache contents and registers
  logic [ID_W-1:0]                   tag_mem   [SLOT_N];
  logic [CNT_W-1:0]                  best_mem  [SLOT_N];
  bit                                valid_mem [SLOT_N];
  logic [sdmc_pkg::TOTAL_W-1:0]      lookups_seen;
  logic [sdmc_pkg::TOTAL_W-1:0]      hits_seen;
  logic [sdmc_pkg::SLOT_COUNT_W-1:0] slot_count_reg;
  logic [sdmc_pkg::UNIT_LIMIT_W-1:0] unit_limit_reg;

  cache_result_t pending_results[$];
  int unsigned   id_pool[POOL_N];
  int            mismatches  = 0;
  int unsigned   cycles      = 0;
  int            hold_cycles = 0;
  int            rx_wait     = 0;
  bit            tx_jitter   = 1'b0;
  bit            rx_jitter   = 1'b0;

  function automatic int unsigned active_slots();
    int unsigned n;
    n = 32'(slot_count_reg);
    if (n > unit_limit_reg) n = 32'(unit_limit_reg);
    if (n < 1) n = 1;
    if (n > SLOT_N) n = SLOT_N;
    return n;
  endfunction

  function automatic cache_result_t predict_cache(logic [sdmc_pkg::OP_W-1:0] op,
                                                  logic [ID_W-1:0] id,
                                                  logic elig, logic [CNT_W-1:0] cnt);
    cache_result_t res;
    int unsigned   slot;
    slot = 32'(id) % active_slots();
    res  = '0;
    case (op)
      sdmc_pkg::OP_PRELOAD: begin
        res.slot = slot[sdmc_pkg::SLOT_INDEX_W-1:0];
        if (int'(id) < int'(unit_limit_reg) && elig && cnt > best_mem[slot]) begin
          tag_mem[slot]   = id;
          best_mem[slot]  = cnt;
          valid_mem[slot] = 1'b1;
        end
      end
      sdmc_pkg::OP_LOOKUP: begin
        res.slot = slot[sdmc_pkg::SLOT_INDEX_W-1:0];
        lookups_seen++;
        if (valid_mem[slot] && tag_mem[slot] == id) begin
          res.hit = 1'b1;
          hits_seen++;
        end
      end
      sdmc_pkg::OP_CLEAR: begin
        lookups_seen = '0;
        hits_seen    = '0;
      end
      default: ;
    endcase
    res.accesses = lookups_seen;
    res.hits     = hits_seen;
    return res;
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < SLOT_N; i++) begin
      tag_mem[i]   = '0;
      best_mem[i]  = '0;
      valid_mem[i] = 1'b0;
    end
    lookups_seen   = '0;
    hits_seen      = '0;
    slot_count_reg = sdmc_pkg::SLOT_COUNT_RST;
    unit_limit_reg = sdmc_pkg::UNIT_LIMIT_RST;
  endtask

  // valid stays high after a beat; it drops only for a random gap before the next item
  task automatic send_item(logic [sdmc_pkg::OP_W-1:0] op, logic [ID_W-1:0] id, logic elig,
                           logic [CNT_W-1:0] cnt);
    int gap;
    gap = tx_jitter ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    unit_id_i         <= id;
    eligible_i        <= elig;
    contained_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.insert(pending_results.size(), predict_cache(op, id, elig, cnt));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sdmc_pkg::CFG_IDX_W-1:0] idx,
                           logic [sdmc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sdmc_pkg::CFG_SLOT_COUNT) slot_count_reg = data[sdmc_pkg::SLOT_COUNT_W-1:0];
    else unit_limit_reg = data[sdmc_pkg::UNIT_LIMIT_W-1:0];
    @(posedge clk_i);
  endtask

  // half the pool lands in the same slots as the other half
  task automatic build_pool();
    int unsigned cap;
    int unsigned n;
    cap = 32'(unit_limit_reg);
    if (cap == 0 || cap > ID_MAX + 1) cap = ID_MAX + 1;
    n = active_slots();
    for (int i = 0; i < POOL_N / 2; i++) id_pool[i] = $urandom_range(0, cap - 1);
    for (int i = POOL_N / 2; i < POOL_N; i++)
      id_pool[i] = (id_pool[i - POOL_N / 2] + n * $urandom_range(1, 3)) & ID_MAX;
  endtask

  task automatic send_random_items(int count);
    logic [sdmc_pkg::OP_W-1:0] op;
    logic [ID_W-1:0]           id;
    logic [CNT_W-1:0]          cnt;
    logic                      elig;
    int unsigned               r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = sdmc_pkg::OP_PRELOAD;
      else if (r < 85) op = sdmc_pkg::OP_LOOKUP;
      else if (r < 95) op = sdmc_pkg::OP_CLEAR;
      else op = OP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 60) id = ID_W'(id_pool[$urandom_range(0, POOL_N - 1)]);
      else if (r < 75) begin
        case ($urandom_range(0, 3))
          0: id = ID_W'(unit_limit_reg - 21'd1);
          1: id = unit_limit_reg[ID_W-1:0];
          2: id = '0;
          default: id = ID_MAX;
        endcase
      end else id = ID_W'($urandom);
      elig = ($urandom_range(0, 6) != 0);
      case ($urandom_range(0, 7))
        0, 1, 2: cnt = CNT_W'($urandom_range(0, 3));
        3, 4:    cnt = CNT_W'($urandom_range(0, 255));
        5, 6:    cnt = CNT_W'($urandom);
        default: cnt = '1;
      endcase
      send_item(op, id, elig, cnt);
    end
  endtask

  task automatic test_empty_and_rejects();
    send_item(sdmc_pkg::OP_LOOKUP, 20'd5, 1'b0, '0);       // empty slot is a miss
    send_item(sdmc_pkg::OP_PRELOAD, 20'd5, 1'b1, '0);      // zero count never cached
    send_item(sdmc_pkg::OP_LOOKUP, 20'd5, 1'b1, '1);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd5, 1'b0, 24'd100); // not cacheable
    send_item(sdmc_pkg::OP_LOOKUP, 20'd5, 1'b0, '0);
    send_item(sdmc_pkg::OP_PRELOAD, ID_MAX, 1'b1, '1);
    send_item(sdmc_pkg::OP_LOOKUP, ID_MAX, 1'b1, '1);
  endtask

  task automatic test_ties_and_replacement();
    send_item(sdmc_pkg::OP_PRELOAD, 20'd5, 1'b1, 24'd10);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd1029, 1'b1, 24'd10); // tie keeps the first one
    send_item(sdmc_pkg::OP_LOOKUP, 20'd1029, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd5, 1'b0, '0);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd1029, 1'b1, 24'd11);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd1029, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd5, 1'b0, '0);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd0, 1'b1, 24'd1);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd0, 1'b0, '0);
  endtask

  task automatic test_counters_and_unknown_op();
    send_item(sdmc_pkg::OP_CLEAR, ID_MAX, 1'b1, '1);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd0, 1'b0, '0);
    send_item(OP_UNUSED, ID_MAX, 1'b1, '1);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd1023, 1'b1, '1);   // valid slot, other tag
    send_item(OP_UNUSED, 20'd0, 1'b0, '0);
  endtask

  task automatic test_config_extremes();
    settle();
    write_reg(sdmc_pkg::CFG_UNIT_LIMIT, '0);              // zero limit drops every preload
    send_item(sdmc_pkg::OP_PRELOAD, 20'd7, 1'b1, '1);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd7, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd0, 1'b0, '0);
    settle();
    write_reg(sdmc_pkg::CFG_SLOT_COUNT, '0);              // zero count acts as one slot
    write_reg(sdmc_pkg::CFG_UNIT_LIMIT, sdmc_pkg::UNIT_LIMIT_RST);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd0, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, ID_MAX, 1'b0, '0);
    settle();
    write_reg(sdmc_pkg::CFG_SLOT_COUNT, 21'h1FF803);      // upper data bits are not stored
    send_item(sdmc_pkg::OP_LOOKUP, ID_MAX, 1'b1, '1);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd4, 1'b1, 24'd2);
    settle();
    write_reg(sdmc_pkg::CFG_SLOT_COUNT, 21'd2047);
    write_reg(sdmc_pkg::CFG_UNIT_LIMIT, 21'd100);         // limit below the count sets modulus
    send_item(sdmc_pkg::OP_PRELOAD, 20'd99, 1'b1, 24'd5);
    send_item(sdmc_pkg::OP_PRELOAD, 20'd100, 1'b1, 24'd9);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd99, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd100, 1'b0, '0);
    send_item(sdmc_pkg::OP_LOOKUP, 20'd4, 1'b0, '0);      // stored under the old modulus
    settle();
  endtask

  task automatic test_backpressure();
    write_reg(sdmc_pkg::CFG_SLOT_COUNT, 21'd16);
    write_reg(sdmc_pkg::CFG_UNIT_LIMIT, sdmc_pkg::UNIT_LIMIT_RST);
    build_pool();
    tx_jitter   = 1'b0;
    hold_cycles = 250;
    send_random_items(14);
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned sc_set [8] = '{1024, 1, 2047, 13, 64, 0, 0, 1024};
    int unsigned ul_set [8] = '{1048576, 1048576, 1048575, 1048576, 40, 0, 0, 1048576};
    for (int p = 0; p < 8; p++) begin
      if (p == 6) begin
        sc_set[p] = $urandom_range(1, SLOT_N);
        ul_set[p] = $urandom_range(1, 1 << ID_W);
      end
      write_reg(sdmc_pkg::CFG_SLOT_COUNT, sdmc_pkg::CFG_DATA_W'(sc_set[p]));
      write_reg(sdmc_pkg::CFG_UNIT_LIMIT, sdmc_pkg::CFG_DATA_W'(ul_set[p]));
      build_pool();
      tx_jitter = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : $urandom_range(0, 1);
      rx_jitter = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : $urandom_range(0, 1);
      send_random_items(80);
      settle();
    end
  endtask

  // result side stall: random waits after each beat when rx_jitter is set, plus the long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) rx_wait = rx_jitter ? $urandom_range(0, 11) : 0;
      else if (rx_wait > 0) rx_wait--;
      out_stall_i <= (rx_wait > 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    cache_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: hit %0d slot %0d accesses %0d hits %0d",
                   hit_o, slot_index_o, access_count_o, hit_count_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit || slot_index_o !== want.slot ||
            access_count_o !== want.accesses || hit_count_o !== want.hits) begin
          if (mismatches < 10)
            $display({"mismatch: expected hit %0d slot %0d accesses %0d hits %0d,",
                      " got %0d %0d %0d %0d"},
                     want.hit, want.slot, want.accesses, want.hits,
                     hit_o, slot_index_o, access_count_o, hit_count_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    test_empty_and_rejects();
    test_ties_and_replacement();
    test_counters_and_unknown_op();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
